>>> design/sgc_pkg.sv
// Package for the step-gated click generator.
// Holds the shared types, register codes, reset values and the quarter-wave sine entry
// function. It depends on nothing.
package sgc_pkg;

    // Fixed widths of the transaction fields
    localparam int SAMPLE_BITS = 16;
    localparam int COUNT_W     = 16;
    localparam int STEP_OUT_W  = 4;
    localparam int ENV_W       = 17;
    localparam int MAG_W       = 15;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_STEPS      = 16;
    localparam int DEF_PHASE_BITS     = 32;
    localparam int DEF_SINE_ADDR_BITS = 8;

    // Envelope in Q1.16
    localparam logic [ENV_W-1:0] ENV_ONE   = 17'd65536;
    localparam logic [ENV_W-1:0] ENV_FLOOR = 17'd7;

    // Register reset values
    localparam logic [4:0]  RST_STEP_COUNT      = 5'd8;
    localparam logic [15:0] RST_STEP_ENABLE     = 16'hFFFF;
    localparam logic [15:0] RST_VOLUME          = 16'd52429;
    localparam logic [31:0] RST_PHASE_INC       = 32'd268435456;
    localparam logic [15:0] RST_DECAY_FACTOR    = 16'd65195;
    localparam logic [15:0] RST_CLICK_MAX_TICKS = 16'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_COUNT      = 3'd0,
        CFG_STEP_ENABLE     = 3'd1,
        CFG_VOLUME          = 3'd2,
        CFG_PHASE_INC       = 3'd3,
        CFG_DECAY_FACTOR    = 3'd4,
        CFG_CLICK_MAX_TICKS = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic               boundary;
        logic [COUNT_W-1:0] subdivision_count;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] audio_sample;
        logic [STEP_OUT_W-1:0]         current_step;
        logic                          click_active;
        logic                          gate_fired;
    } t_out_item;

    // Q30 coefficients of sin(pi/2 * x)
    localparam longint unsigned SINE_C1 = 64'd1686629713;
    localparam longint unsigned SINE_C3 = 64'd693598669;
    localparam longint unsigned SINE_C5 = 64'd85569306;
    localparam longint unsigned SINE_C7 = 64'd5026993;
    localparam longint unsigned SINE_C9 = 64'd172272;

    // One quarter-wave entry in Q15; called with constants only, so it folds at elaboration.
    function automatic logic [MAG_W-1:0] sine_entry(input int unsigned addr_bits,
                                                    input int unsigned idx);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned x3;
        longint unsigned x5;
        longint unsigned x7;
        longint unsigned x9;
        longint unsigned pos;
        longint unsigned neg;
        longint unsigned s;
        longint unsigned q;
        x   = (64'(idx) << 30) >> addr_bits;
        x2  = (x * x) >> 30;
        x3  = (x2 * x) >> 30;
        x5  = (x3 * x2) >> 30;
        x7  = (x5 * x2) >> 30;
        x9  = (x7 * x2) >> 30;
        pos = ((SINE_C1 * x) >> 30) + ((SINE_C5 * x5) >> 30) + ((SINE_C9 * x9) >> 30);
        neg = ((SINE_C3 * x3) >> 30) + ((SINE_C7 * x7) >> 30);
        s   = (pos > neg) ? (pos - neg) : 64'd0;
        q   = (s + 64'd16384) >> 15;
        if (q > 64'd32767) begin
            q = 64'd32767;
        end
        return q[MAG_W-1:0];
    endfunction

endpackage

>>> design/step_gated_click_generator.sv
// Step-gated click generator, top level.
// Uses sgc_pkg, sgc_serial_div, sgc_serial_mult and sgc_sine_rom.
//
//  Channel | Direction | Handshake                  | Payload
//  --------+-----------+----------------------------+--------------------------------
//  in      | sink      | i_in_valid / o_in_stall    | i_in_item  (t_in_item)
//  out     | source    | o_out_valid / i_out_stall  | o_out_item (t_out_item)
//  cfg     | sink      | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One transaction in gives one transaction out. While no click sounds a tick goes from
// evaluation straight to the write-back; while one sounds it runs two multiply steps, the
// first running the 15-bit and 16-bit products side by side, the second the 16-bit volume
// product, one multiplier bit per cycle. A boundary adds the step remainder first, which
// takes one dividend bit per cycle.
// Reset (synchronous, active low) loads the register defaults and silences the click.
// The result sits in an output register, so the next tick is taken while it waits; a stall
// on the output holds only the final write-back once that register is still full.
module step_gated_click_generator
    import sgc_pkg::*;
#(
    parameter int MAX_STEPS      = DEF_MAX_STEPS,
    parameter int PHASE_BITS     = DEF_PHASE_BITS,
    parameter int SINE_ADDR_BITS = DEF_SINE_ADDR_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    // Step counter widths follow from the pattern length limit
    localparam int CNT_W      = $clog2(MAX_STEPS + 1);
    localparam int STEP_W     = $clog2(MAX_STEPS);
    localparam logic [7:0] MAX_STEPS_V = 8'(MAX_STEPS);
    // Product widths of the serial multipliers
    localparam int MAG_PROD_W = ENV_W + MAG_W;
    localparam int ENV_PROD_W = ENV_W + 16;
    localparam int VOL_PROD_W = MAG_PROD_W + 16;
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_CAP = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_EVAL,
        S_ROM,
        S_MUL1,
        S_MUL2,
        S_DONE
    } t_state;

    t_state r_state, n_state;

    // Configuration registers
    logic [4:0]  r_step_count, n_step_count;
    logic [15:0] r_step_enable, n_step_enable;
    logic [15:0] r_volume, n_volume;
    logic [31:0] r_phase_inc, n_phase_inc;
    logic [15:0] r_decay, n_decay;
    logic [15:0] r_max_ticks, n_max_ticks;

    // Click state
    logic [PHASE_BITS-1:0]  r_phase, n_phase;
    logic [ENV_W-1:0]       r_env, n_env;
    logic [15:0]            r_tick, n_tick;
    logic                   r_sounding, n_sounding;
    logic [STEP_W-1:0]      r_step_pos, n_step_pos;
    logic                   r_fired, n_fired;
    logic [SAMPLE_BITS-1:0] r_sample, n_sample;

    // Output register
    t_out_item r_out, n_out;
    logic      r_out_valid, n_out_valid;

    // Unit handshakes
    logic                  w_div_start, w_mul1_start, w_mul2_start;
    logic                  w_div_busy, w_mag_busy, w_env_busy, w_vol_busy;
    logic [CNT_W-1:0]      w_div_rem;
    logic [MAG_PROD_W-1:0] w_mag_prod;
    logic [ENV_PROD_W-1:0] w_env_prod;
    logic [VOL_PROD_W-1:0] w_vol_prod;
    logic [MAG_W-1:0]      w_rom_mag;
    logic                  w_rom_neg;
    logic                  w_rom_load;

    logic                   w_in_accept, w_out_free, w_cfg_write;
    logic [7:0]             w_cnt_wide;
    logic [CNT_W-1:0]       w_cnt;
    logic [STEP_W+3:0]      w_pos_ext;
    logic                   w_fire;
    logic [ENV_W-1:0]       w_env_next;
    logic [15:0]            w_tick_next;
    logic [PHASE_BITS-1:0]  w_phase_next;
    logic                   w_click_end;
    logic [SAMPLE_BITS-1:0] w_mag_raw, w_mag_cap, w_sample;
    logic [STEP_W+3:0]      w_step_ext;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_cfg_write = i_cfg_valid && o_cfg_ready;

    // Clamp the pattern length to 1..MAX_STEPS
    assign w_cnt_wide = (r_step_count == 5'd0) ? 8'd1 :
                        ({3'b0, r_step_count} > MAX_STEPS_V) ? MAX_STEPS_V :
                        {3'b0, r_step_count};
    assign w_cnt      = w_cnt_wide[CNT_W-1:0];

    // Step enable: bits past the mask read as clear
    assign w_pos_ext = {4'b0, w_div_rem[STEP_W-1:0]};
    assign w_fire    = ((w_pos_ext >> 4) == '0) && r_step_enable[w_pos_ext[3:0]];

    // Per-tick advance of the click
    assign w_env_next   = w_env_prod[ENV_PROD_W-1 -: ENV_W];
    assign w_tick_next  = r_tick + 16'd1;
    assign w_phase_next = r_phase + r_phase_inc[31 -: PHASE_BITS];
    assign w_click_end  = (w_tick_next >= r_max_ticks) || (w_env_next < ENV_FLOOR);

    // Scale, saturate and apply the quadrant sign
    assign w_mag_raw = w_vol_prod[VOL_PROD_W-1 -: SAMPLE_BITS];
    assign w_mag_cap = w_mag_raw[SAMPLE_BITS-1] ? SAMPLE_CAP : w_mag_raw;
    assign w_sample  = w_rom_neg ? (SAMPLE_BITS'(0) - w_mag_cap) : w_mag_cap;

    assign w_step_ext = {4'b0, r_step_pos};
    assign w_rom_load = (r_state == S_EVAL);

    always_comb begin
        n_state       = r_state;
        n_step_count  = r_step_count;
        n_step_enable = r_step_enable;
        n_volume      = r_volume;
        n_phase_inc   = r_phase_inc;
        n_decay       = r_decay;
        n_max_ticks   = r_max_ticks;
        n_phase       = r_phase;
        n_env         = r_env;
        n_tick        = r_tick;
        n_sounding    = r_sounding;
        n_step_pos    = r_step_pos;
        n_fired       = r_fired;
        n_sample      = r_sample;
        n_out         = r_out;
        n_out_valid   = r_out_valid && i_out_stall;
        w_div_start   = 1'b0;
        w_mul1_start  = 1'b0;
        w_mul2_start  = 1'b0;

        if (w_cfg_write) begin
            case (i_cfg_index)
                CFG_STEP_COUNT:      n_step_count  = i_cfg_data[4:0];
                CFG_STEP_ENABLE:     n_step_enable = i_cfg_data[15:0];
                CFG_VOLUME:          n_volume      = i_cfg_data[15:0];
                CFG_PHASE_INC:       n_phase_inc   = i_cfg_data;
                CFG_DECAY_FACTOR:    n_decay       = i_cfg_data[15:0];
                CFG_CLICK_MAX_TICKS: n_max_ticks   = i_cfg_data[15:0];
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_accept) begin
                    n_fired = 1'b0;
                    if (i_in_item.boundary) begin
                        w_div_start = 1'b1;
                        n_state     = S_DIV;
                    end else begin
                        n_state = S_EVAL;
                    end
                end
            end
            S_DIV: begin
                // Report the step; retrigger only on an enabled one
                if (!w_div_busy) begin
                    n_step_pos = w_div_rem[STEP_W-1:0];
                    if (w_fire) begin
                        n_fired    = 1'b1;
                        n_sounding = 1'b1;
                        n_env      = ENV_ONE;
                        n_tick     = '0;
                        n_phase    = '0;
                    end
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (r_sounding) begin
                    n_state = S_ROM;
                end else begin
                    n_sample = '0;
                    n_state  = S_DONE;
                end
            end
            S_ROM: begin
                w_mul1_start = 1'b1;
                n_state      = S_MUL1;
            end
            S_MUL1: begin
                // Both products use the old envelope; advance state once they land
                if (!w_mag_busy && !w_env_busy) begin
                    w_mul2_start = 1'b1;
                    n_env        = w_env_next;
                    n_tick       = w_tick_next;
                    n_phase      = w_phase_next;
                    n_sounding   = !w_click_end;
                    n_state      = S_MUL2;
                end
            end
            S_MUL2: begin
                if (!w_vol_busy) begin
                    n_sample = w_sample;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                // Hold until the output register has room
                if (w_out_free) begin
                    n_out.audio_sample = $signed(r_sample);
                    n_out.current_step = w_step_ext[3:0];
                    n_out.click_active = r_sounding;
                    n_out.gate_fired   = r_fired;
                    n_out_valid        = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_step_count  <= RST_STEP_COUNT;
            r_step_enable <= RST_STEP_ENABLE;
            r_volume      <= RST_VOLUME;
            r_phase_inc   <= RST_PHASE_INC;
            r_decay       <= RST_DECAY_FACTOR;
            r_max_ticks   <= RST_CLICK_MAX_TICKS;
            r_phase       <= '0;
            r_env         <= '0;
            r_tick        <= '0;
            r_sounding    <= 1'b0;
            r_step_pos    <= '0;
            r_fired       <= 1'b0;
            r_sample      <= '0;
            r_out         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_step_count  <= n_step_count;
            r_step_enable <= n_step_enable;
            r_volume      <= n_volume;
            r_phase_inc   <= n_phase_inc;
            r_decay       <= n_decay;
            r_max_ticks   <= n_max_ticks;
            r_phase       <= n_phase;
            r_env         <= n_env;
            r_tick        <= n_tick;
            r_sounding    <= n_sounding;
            r_step_pos    <= n_step_pos;
            r_fired       <= n_fired;
            r_sample      <= n_sample;
            r_out         <= n_out;
            r_out_valid   <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Step index: subdivision count modulo the clamped pattern length
    sgc_serial_div #(
        .DVD_W (COUNT_W),
        .DIV_W (CNT_W)
    ) u_step_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (i_in_item.subdivision_count),
        .i_divisor  (w_cnt),
        .o_busy     (w_div_busy),
        .o_rem      (w_div_rem)
    );

    sgc_sine_rom #(
        .PHASE_BITS     (PHASE_BITS),
        .SINE_ADDR_BITS (SINE_ADDR_BITS)
    ) u_sine_rom (
        .i_clk   (i_clk),
        .i_load  (w_rom_load),
        .i_phase (r_phase),
        .o_mag   (w_rom_mag),
        .o_neg   (w_rom_neg)
    );

    // |sine| x envelope
    sgc_serial_mult #(
        .A_W (ENV_W),
        .B_W (MAG_W)
    ) u_mag_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul1_start),
        .i_a     (r_env),
        .i_b     (w_rom_mag),
        .o_busy  (w_mag_busy),
        .o_prod  (w_mag_prod)
    );

    // envelope x decay, runs alongside the magnitude product
    sgc_serial_mult #(
        .A_W (ENV_W),
        .B_W (16)
    ) u_env_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul1_start),
        .i_a     (r_env),
        .i_b     (r_decay),
        .o_busy  (w_env_busy),
        .o_prod  (w_env_prod)
    );

    // (|sine| x envelope) x volume
    sgc_serial_mult #(
        .A_W (MAG_PROD_W),
        .B_W (16)
    ) u_vol_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul2_start),
        .i_a     (w_mag_prod),
        .i_b     (r_volume),
        .o_busy  (w_vol_busy),
        .o_prod  (w_vol_prod)
    );

endmodule

>>> design/sgc_serial_div.sv
// Bit-serial restoring divider that keeps only the remainder.
// One dividend bit per cycle; depends on nothing outside this file.
module sgc_serial_div #(
    parameter int DVD_W = 16,
    parameter int DIV_W = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DIV_W-1:0] i_divisor,
    output logic             o_busy,
    output logic [DIV_W-1:0] o_rem
);
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DIV_W-1:0] r_rem;
    logic [DVD_W-1:0] r_dvd;
    logic [DIV_W-1:0] r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;

    logic [DIV_W:0] w_trial;
    logic [DIV_W:0] w_diff;
    logic           w_ge;

    assign w_trial = {r_rem, r_dvd[DVD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_ge    = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DVD_W);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - CNT_W'(1);
            r_busy <= (r_cnt != CNT_W'(1));
        end
    end

    // Payload path: shift the dividend in, subtract when the trial fits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DIV_W-1:0] : w_trial[DIV_W-1:0];
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
        end
    end

    assign o_busy = r_busy;
    assign o_rem  = r_rem;
endmodule

>>> design/sgc_serial_mult.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Unsigned operands; depends on nothing outside this file.
module sgc_serial_mult #(
    parameter int A_W = 16,
    parameter int B_W = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [A_W-1:0]     i_a,
    input  logic [B_W-1:0]     i_b,
    output logic               o_busy,
    output logic [A_W+B_W-1:0] o_prod
);
    localparam int CNT_W = $clog2(B_W + 1);

    logic [A_W-1:0]     r_a;
    logic [A_W+B_W-1:0] r_prod;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;

    logic [A_W:0] w_sum;

    // Add the multiplicand into the high half when the low bit is set
    assign w_sum = {1'b0, r_prod[A_W+B_W-1:B_W]} + (r_prod[0] ? {1'b0, r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(B_W);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - CNT_W'(1);
            r_busy <= (r_cnt != CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a    <= i_a;
            r_prod <= {{A_W{1'b0}}, i_b};
        end else if (r_busy) begin
            r_prod <= {w_sum, r_prod[B_W-1:1]};
        end
    end

    assign o_busy = r_busy;
    assign o_prod = r_prod;
endmodule

>>> design/sgc_sine_rom.sv
// Quarter-wave sine lookup with quadrant folding and a registered read.
// Uses sgc_pkg for the table entry function and the magnitude width.
module sgc_sine_rom
    import sgc_pkg::*;
#(
    parameter int PHASE_BITS     = DEF_PHASE_BITS,
    parameter int SINE_ADDR_BITS = DEF_SINE_ADDR_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_load,
    input  logic [PHASE_BITS-1:0] i_phase,
    output logic [MAG_W-1:0]      o_mag,
    output logic                  o_neg
);
    localparam int QTR_LEN = 1 << SINE_ADDR_BITS;
    localparam logic [SINE_ADDR_BITS:0] QTR_LEN_V = (SINE_ADDR_BITS + 1)'(QTR_LEN);

    logic [MAG_W-1:0]          w_rom [0:QTR_LEN];
    logic [1:0]                w_quad;
    logic [SINE_ADDR_BITS-1:0] w_idx;
    logic [SINE_ADDR_BITS:0]   w_addr;
    logic [MAG_W-1:0]          r_mag;
    logic                      r_neg;

    for (genvar g = 0; g <= QTR_LEN; g++) begin : g_rom
        assign w_rom[g] = sine_entry(SINE_ADDR_BITS, g);
    end

    assign w_quad = i_phase[PHASE_BITS-1 -: 2];
    assign w_idx  = i_phase[PHASE_BITS-3 -: SINE_ADDR_BITS];
    // Odd quadrants run the table backward
    assign w_addr = w_quad[0] ? (QTR_LEN_V - {1'b0, w_idx}) : {1'b0, w_idx};

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_mag <= w_rom[w_addr];
            r_neg <= w_quad[1];
        end
    end

    assign o_mag = r_mag;
    assign o_neg = r_neg;
endmodule

>>> verif/tb_step_gated_click_generator.sv
// Self-checking testbench for the step-gated click generator.
// Depends on sgc_pkg and step_gated_click_generator; a tracking class predicts every
// tick's result while plain tasks drive the tick and register channels.
module tb_step_gated_click_generator
    import sgc_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    // Block geometry as instantiated (default parameters)
    localparam int STEP_SLOTS   = 16;
    localparam int QW_BITS      = DEF_SINE_ADDR_BITS;
    localparam int QW_LEN       = 1 << QW_BITS;
    localparam int SAMPLE_SHIFT = 48 - SAMPLE_BITS;
    localparam longint unsigned SAMPLE_CAP = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

    // Q30 coefficients of sin(pi/2 * x), odd terms up to the ninth
    localparam longint unsigned K1 = 64'd1686629713;
    localparam longint unsigned K3 = 64'd693598669;
    localparam longint unsigned K5 = 64'd85569306;
    localparam longint unsigned K7 = 64'd5026993;
    localparam longint unsigned K9 = 64'd172272;

    localparam logic [ENV_W-1:0] ENV_FULL = 17'h10000;
    localparam logic [ENV_W-1:0] ENV_MIN  = 17'd7;

    // Indexes past the last register; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'(CFG_CLICK_MAX_TICKS) + 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = '1;
    localparam int REG_COUNT = int'(CFG_CLICK_MAX_TICKS) + 1;

    localparam int RANDOM_PHASES   = 9;
    localparam int TICKS_PER_PHASE = 180;
    localparam int MAX_WAIT        = 17;
    localparam int DRAIN_CYCLES    = 64;
    localparam int QUIET_LIMIT     = 3000;

    typedef enum int {IDLE_NONE, IDLE_FULL, IDLE_SPARSE} t_idle;
    typedef enum int {SET_RANDOM, SET_LOW, SET_HIGH} t_bias;

    // Tracks the click state, predicts each tick's result and checks results in order.
    class click_ledger;
        logic [4:0]       step_count;
        logic [15:0]      step_enable;
        logic [15:0]      volume;
        logic [31:0]      phase_inc;
        logic [15:0]      decay;
        logic [15:0]      max_ticks;
        logic [31:0]      tone_phase;
        logic [ENV_W-1:0] envelope;
        logic [15:0]      tick_count;
        bit               sounding;
        logic [3:0]       step_pos;
        logic [MAG_W-1:0] sine_q15 [0:QW_LEN];
        t_out_item        owed_ticks [$];
        int               failures;

        function new();
            longint unsigned u;
            longint unsigned u2;
            longint unsigned u3;
            longint unsigned u5;
            longint unsigned u7;
            longint unsigned u9;
            longint unsigned up;
            longint unsigned dn;
            longint unsigned q;
            step_count  = 5'd8;
            step_enable = 16'hFFFF;
            volume      = 16'd52429;
            phase_inc   = 32'd268435456;
            decay       = 16'd65195;
            max_ticks   = 16'd480;
            tone_phase  = '0;
            envelope    = '0;
            tick_count  = '0;
            sounding    = 1'b0;
            step_pos    = '0;
            failures    = 0;
            // Quarter-wave table: polynomial in Q30, rounded half up to Q15, capped
            for (int k = 0; k <= QW_LEN; k++) begin
                u  = (64'(k) << 30) >> QW_BITS;
                u2 = (u * u) >> 30;
                u3 = (u2 * u) >> 30;
                u5 = (u3 * u2) >> 30;
                u7 = (u5 * u2) >> 30;
                u9 = (u7 * u2) >> 30;
                up = ((K1 * u) >> 30) + ((K5 * u5) >> 30) + ((K9 * u9) >> 30);
                dn = ((K3 * u3) >> 30) + ((K7 * u7) >> 30);
                q  = ((up > dn ? up - dn : 64'd0) + 64'd16384) >> 15;
                sine_q15[k] = MAG_W'(q > 64'd32767 ? 64'd32767 : q);
            end
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (t_cfg_reg'(idx))
                CFG_STEP_COUNT:      step_count  = data[4:0];
                CFG_STEP_ENABLE:     step_enable = data[15:0];
                CFG_VOLUME:          volume      = data[15:0];
                CFG_PHASE_INC:       phase_inc   = data;
                CFG_DECAY_FACTOR:    decay       = data[15:0];
                CFG_CLICK_MAX_TICKS: max_ticks   = data[15:0];
                default: ;
            endcase
        endfunction

        // Advance the click by one tick and return what the block must report.
        function t_out_item advance_click(t_in_item it);
            t_out_item        r;
            int unsigned      span;
            logic [1:0]       quad;
            logic [QW_BITS-1:0] addr;
            logic [MAG_W-1:0] mag;
            longint unsigned  prod;
            logic [15:0]      level;
            r = '0;
            if (it.boundary) begin
                // Clamp the pattern length to 1..STEP_SLOTS
                span = (step_count == 0) ? 1 :
                       ((step_count > STEP_SLOTS) ? STEP_SLOTS : step_count);
                step_pos = 4'(it.subdivision_count % span);
                if (step_enable[step_pos]) begin
                    // Restart first so this very tick carries the first click sample
                    r.gate_fired = 1'b1;
                    sounding     = 1'b1;
                    envelope     = ENV_FULL;
                    tick_count   = '0;
                    tone_phase   = '0;
                end
            end
            if (sounding) begin
                quad = tone_phase[31:30];
                addr = QW_BITS'(tone_phase >> (30 - QW_BITS));
                mag  = quad[0] ? sine_q15[QW_LEN - int'(addr)] : sine_q15[addr];
                prod = (64'(mag) * 64'(envelope) * 64'(volume)) >> SAMPLE_SHIFT;
                if (prod > SAMPLE_CAP) begin
                    prod = SAMPLE_CAP;
                end
                level = prod[15:0];
                r.audio_sample = quad[1] ? (16'd0 - level) : level;
                tone_phase = tone_phase + phase_inc;
                envelope   = ENV_W'((64'(envelope) * 64'(decay)) >> 16);
                tick_count = tick_count + 16'd1;
                if (tick_count >= max_ticks || envelope < ENV_MIN) begin
                    sounding = 1'b0;
                end
            end
            r.current_step = step_pos;
            r.click_active = sounding;
            return r;
        endfunction

        function void log_tick(t_in_item it);
            owed_ticks.insert(owed_ticks.size(), advance_click(it));
        endfunction

        function void match_tick(t_out_item got);
            t_out_item want;
            if (owed_ticks.size() == 0) begin
                $error("result with no tick outstanding: %p", got);
                failures++;
                return;
            end
            want = owed_ticks.pop_front();
            if (got.audio_sample !== want.audio_sample) begin
                $error("audio_sample: expected %0d, got %0d",
                       want.audio_sample, got.audio_sample);
                failures++;
            end
            if (got.current_step !== want.current_step) begin
                $error("current_step: expected %0d, got %0d",
                       want.current_step, got.current_step);
                failures++;
            end
            if (got.click_active !== want.click_active) begin
                $error("click_active: expected %0b, got %0b",
                       want.click_active, got.click_active);
                failures++;
            end
            if (got.gate_fired !== want.gate_fired) begin
                $error("gate_fired: expected %0b, got %0b", want.gate_fired, got.gate_fired);
                failures++;
            end
        endfunction

        function int pending();
            return owed_ticks.size();
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in_item              in_item   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    click_ledger ledger = new();
    logic [31:0] regs_next [REG_COUNT];
    t_idle       in_mode  = IDLE_FULL;
    t_idle       out_mode = IDLE_FULL;
    int          stall_left  = 0;
    int          quiet_count = 0;

    step_gated_click_generator uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // Number of idle cycles before the next transaction on one side
    function automatic int draw_wait(t_idle mode);
        case (mode)
            IDLE_NONE:   return 0;
            IDLE_FULL:   return $urandom_range(0, MAX_WAIT);
            default:     return ($urandom_range(0, 7) == 0) ? $urandom_range(0, MAX_WAIT) : 0;
        endcase
    endfunction

    function automatic t_in_item mk_tick(logic boundary, logic [COUNT_W-1:0] count);
        t_in_item it;
        it.boundary          = boundary;
        it.subdivision_count = count;
        return it;
    endfunction

    // Pick a register value: a low or high extreme, or something typical for that register
    function automatic logic [31:0] draw_setting(t_cfg_reg r, t_bias bias);
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] any;
        logic [31:0] keep;
        logic [31:0] pick;
        bit          coin;
        coin = $urandom_range(0, 1);
        case (r)
            CFG_STEP_COUNT: begin
                lo = 32'd0; hi = 32'd31; any = $urandom_range(1, 20); keep = 32'h1F;
            end
            CFG_STEP_ENABLE: begin
                lo = 32'd0; hi = 32'hFFFF; any = $urandom(); keep = 32'hFFFF;
            end
            CFG_VOLUME: begin
                lo = 32'd0; hi = 32'hFFFF; any = $urandom_range(0, 65535); keep = 32'hFFFF;
            end
            CFG_PHASE_INC: begin
                lo = 32'd0; hi = 32'hFFFF_FFFF; any = $urandom(); keep = 32'hFFFF_FFFF;
            end
            CFG_DECAY_FACTOR: begin
                // Favor slow decay so clicks last long enough to overlap boundaries
                lo = 32'd0; hi = 32'hFFFF; keep = 32'hFFFF;
                any = coin ? $urandom_range(60000, 65535) : $urandom_range(0, 65535);
            end
            default: begin
                lo = coin ? 32'd0 : 32'd1; hi = 32'hFFFF; any = $urandom_range(1, 200);
                keep = 32'hFFFF;
            end
        endcase
        if (bias == SET_RANDOM && $urandom_range(0, 3) == 0) begin
            bias = coin ? SET_LOW : SET_HIGH;
        end
        pick = (bias == SET_LOW) ? lo : ((bias == SET_HIGH) ? hi : any);
        // Fill the unused upper data bits; the block must ignore them
        if ($urandom_range(0, 1) == 1) begin
            pick = (pick & keep) | ($urandom() & ~keep);
        end
        return pick;
    endfunction

    // Offer one tick after a random gap; hold it until the block takes it.
    // Valid stays high on return so back-to-back ticks never drop it.
    task automatic push_tick(input t_in_item it);
        int gap;
        gap = draw_wait(in_mode);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        ledger.log_tick(it);
    endtask

    // One register transaction; valid is left high for the next write in the batch
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        ledger.set_reg(idx, data);
    endtask

    // Stop feeding ticks, let every owed result come back, then load regs_next
    task automatic next_phase(input bit with_spare);
        t_cfg_reg r;
        in_valid <= 1'b0;
        while (ledger.pending() != 0) @(posedge clk);
        if (with_spare) begin
            write_reg(CFG_SPARE_LO, $urandom());
            write_reg(CFG_SPARE_HI, $urandom());
        end
        r = r.first();
        do begin
            write_reg(r, regs_next[r]);
            r = r.next();
        end while (r != r.first());
        cfg_valid <= 1'b0;
    endtask

    // Result side: check each result transaction, then draw how long to stall the next one.
    // The stall count only runs down while a result is waiting, so stalls land on results.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            ledger.match_tick(out_item);
            stall_left = draw_wait(out_mode);
        end else if (out_valid && stall_left > 0) begin
            stall_left--;
        end
        out_stall <= (stall_left != 0);
    end

    // Watchdog: give up once no channel has moved a transaction for too long
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            quiet_count <= 0;
        end else if (quiet_count + 1 >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_count <= quiet_count + 1;
        end
    end

    initial begin
        t_cfg_reg         r;
        t_in_item         item;
        logic [COUNT_W-1:0] sub_count;
        int               roll;
        int               spacing;
        int               since;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: an idle tick with a full-scale count but no boundary, then clicks
        // on step 0 and on step 7 (largest count), with a few sounding ticks after each
        push_tick(mk_tick(1'b0, 16'hFFFF));
        push_tick(mk_tick(1'b1, 16'h0000));
        push_tick(mk_tick(1'b0, 16'h0000));
        push_tick(mk_tick(1'b0, 16'h1234));
        push_tick(mk_tick(1'b1, 16'hFFFF));
        push_tick(mk_tick(1'b0, 16'h0000));
        push_tick(mk_tick(1'b0, 16'h0000));

        // Zero step count (acts as one step) and zero click length (one tick only),
        // at full volume, full decay and the largest phase step
        regs_next[CFG_STEP_COUNT]      = 32'd0;
        regs_next[CFG_STEP_ENABLE]     = 32'h0001;
        regs_next[CFG_VOLUME]          = 32'hFFFF;
        regs_next[CFG_PHASE_INC]       = 32'hFFFF_FFFF;
        regs_next[CFG_DECAY_FACTOR]    = 32'hFFFF;
        regs_next[CFG_CLICK_MAX_TICKS] = 32'd0;
        next_phase(1'b0);
        push_tick(mk_tick(1'b1, 16'h3039));
        push_tick(mk_tick(1'b0, 16'h0000));
        push_tick(mk_tick(1'b1, 16'hFFFF));
        push_tick(mk_tick(1'b0, 16'h0000));

        // Step count above the slot count (acts as the maximum) with only odd steps enabled:
        // a boundary on a disabled step must leave the running click alone
        regs_next[CFG_STEP_COUNT]      = 32'd31;
        regs_next[CFG_STEP_ENABLE]     = 32'hAAAA;
        regs_next[CFG_VOLUME]          = 32'd40000;
        regs_next[CFG_PHASE_INC]       = 32'h4000_0000;
        regs_next[CFG_DECAY_FACTOR]    = 32'hFFFF;
        regs_next[CFG_CLICK_MAX_TICKS] = 32'hFFFF;
        next_phase(1'b0);
        push_tick(mk_tick(1'b1, 16'h0003));
        push_tick(mk_tick(1'b0, 16'h0000));
        push_tick(mk_tick(1'b1, 16'h0002));
        push_tick(mk_tick(1'b0, 16'h0000));
        push_tick(mk_tick(1'b1, 16'hFFFF));
        push_tick(mk_tick(1'b0, 16'h0000));
        push_tick(mk_tick(1'b1, 16'h0000));
        push_tick(mk_tick(1'b0, 16'h0000));

        // Random phases: the first at all-low settings, the second at all-high, the rest mixed.
        // Most boundaries follow a running count at a fixed spacing; a few are strays with
        // arbitrary counts or jumps in the count.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            r = r.first();
            do begin
                regs_next[r] = draw_setting(r, (ph == 0) ? SET_LOW :
                                               ((ph == 1) ? SET_HIGH : SET_RANDOM));
                r = r.next();
            end while (r != r.first());
            next_phase(ph == 3);
            in_mode   = t_idle'($urandom_range(0, 2));
            out_mode  = t_idle'($urandom_range(0, 2));
            spacing   = $urandom_range(1, 24);
            sub_count = COUNT_W'($urandom());
            since     = 0;
            for (int n = 0; n < TICKS_PER_PHASE; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 6) begin
                    item = mk_tick(1'b1, COUNT_W'($urandom()));
                end else if (since >= spacing) begin
                    sub_count = (roll < 10) ? COUNT_W'($urandom()) : sub_count + 1'b1;
                    item  = mk_tick(1'b1, sub_count);
                    since = 0;
                end else begin
                    item = mk_tick(1'b0, COUNT_W'($urandom()));
                    since++;
                end
                push_tick(item);
            end
        end

        // Drain, then leave room for any stray result to show up
        in_valid <= 1'b0;
        while (ledger.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (ledger.failures == 0 && ledger.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
